@@ rtl/hesd_pkg.sv @@
// Shared types, constants and named-reference table for the entity decoder.
`timescale 1ns / 1ps

package hesd_pkg;

    localparam int HESD_LOOKAHEAD = 32;
    localparam int HESD_NAMES     = 15;
    localparam int HESD_NAME_MAX  = 6;

    localparam logic [15:0] CH_AMP   = 16'h0026;
    localparam logic [15:0] CH_SEMI  = 16'h003B;
    localparam logic [15:0] CH_HASH  = 16'h0023;
    localparam logic [15:0] CH_LX    = 16'h0078;
    localparam logic [15:0] CH_UX    = 16'h0058;
    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_NBSP  = 16'h00A0;
    localparam logic [15:0] CH_TAB   = 16'h0009;
    localparam logic [15:0] CH_CR    = 16'h000D;

    localparam logic [20:0] CP_MAX    = 21'h10FFFF;
    localparam logic [20:0] CP_PLANE1 = 21'h010000;
    localparam logic [20:0] CP_SUR_LO = 21'h00D800;
    localparam logic [20:0] CP_SUR_HI = 21'h00DFFF;
    localparam logic [15:0] SUR_LEAD  = 16'hD800;
    localparam logic [15:0] SUR_TRAIL = 16'hDC00;

    typedef struct packed {
        logic take;
        logic rd;
        logic push;
        logic push_ram;
    } hesd_cmd_t;

    typedef struct packed {
        logic any;
        logic next_ram;
        logic out_free;
        logic pop_last;
    } hesd_stat_t;

    function automatic logic [2:0] name_len(input logic [3:0] k);
        logic [2:0] r;
        unique case (k)
            4'd0:    r = 3'd4;
            4'd1:    r = 3'd3;
            4'd2:    r = 3'd2;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd4;
            4'd5:    r = 3'd4;
            4'd6:    r = 3'd4;
            4'd7:    r = 3'd4;
            4'd8:    r = 3'd6;
            4'd9:    r = 3'd6;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd5;
            4'd12:   r = 3'd5;
            4'd13:   r = 3'd5;
            4'd14:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [47:0] name_text(input logic [3:0] k);
        logic [47:0] r;
        unique case (k)
            4'd0:    r = {"nbsp", 16'h0};
            4'd1:    r = {"amp", 24'h0};
            4'd2:    r = {"lt", 32'h0};
            4'd3:    r = {"gt", 32'h0};
            4'd4:    r = {"quot", 16'h0};
            4'd5:    r = {"apos", 16'h0};
            4'd6:    r = {"ensp", 16'h0};
            4'd7:    r = {"emsp", 16'h0};
            4'd8:    r = "thinsp";
            4'd9:    r = "middot";
            4'd10:   r = "hellip";
            4'd11:   r = {"ndash", 8'h0};
            4'd12:   r = {"mdash", 8'h0};
            4'd13:   r = {"times", 8'h0};
            4'd14:   r = {"vert", 16'h0};
            default: r = 48'h0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] name_unit(input logic [3:0] k);
        logic [15:0] r;
        unique case (k)
            4'd0:    r = 16'h00A0;
            4'd1:    r = 16'h0026;
            4'd2:    r = 16'h003C;
            4'd3:    r = 16'h003E;
            4'd4:    r = 16'h0022;
            4'd5:    r = 16'h0027;
            4'd6:    r = 16'h2002;
            4'd7:    r = 16'h2003;
            4'd8:    r = 16'h2009;
            4'd9:    r = 16'h00B7;
            4'd10:   r = 16'h2026;
            4'd11:   r = 16'h2013;
            4'd12:   r = 16'h2014;
            4'd13:   r = 16'h00D7;
            4'd14:   r = 16'h007C;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    // character at position pos (0..5) of name k
    function automatic logic [7:0] name_char(input logic [3:0] k, input logic [2:0] pos);
        logic [47:0] t;
        t = name_text(k);
        return 8'(t >> (6'd40 - {pos, 3'b000}));
    endfunction

endpackage

@@ rtl/hesd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hesd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/hesd_ctrl.sv @@
// Control state machine: request intake and result sequencing.
`timescale 1ns / 1ps

module hesd_ctrl import hesd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  hesd_stat_t stat,
    output hesd_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EMIT = 2'd1;
    localparam logic [1:0] S_RAMW = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!stat.any)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.next_ram)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_RAMW;
                end
                else if (stat.out_free)
                begin
                    cmd.push = 1'b1;
                    if (stat.pop_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RAMW:
            begin
                if (stat.out_free)
                begin
                    cmd.push_ram = 1'b1;
                    state_next   = stat.pop_last ? S_IDLE : S_EMIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

@@ rtl/hesd_datapath.sv @@
// Datapath: reference parsing, held-unit RAM, result queue and output register.
`timescale 1ns / 1ps

module hesd_datapath import hesd_pkg::*; #(
    parameter int LOOKAHEAD = HESD_LOOKAHEAD
) (
    input  logic        clk,
    input  logic        rst_n,
    input  hesd_cmd_t   cmd,
    output hesd_stat_t  stat,
    input  logic [15:0] code_unit,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_unit,
    output logic        last_of_run,
    output logic        text_done
);

    localparam int CW = $clog2(LOOKAHEAD + 1);
    localparam int AW = $clog2(LOOKAHEAD);

    // candidate state
    logic          in_ref_reg, in_ref_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          is_num_reg, is_num_next;
    logic          hex_reg, hex_next;
    logic          nfail_reg, nfail_next;
    logic [3:0]    ndig_reg, ndig_next;
    logic [20:0]   val_reg, val_next;
    logic [HESD_NAMES-1:0] mask_reg, mask_next;

    // pending results of the current request
    logic          amp_reg, amp_next;
    logic [CW-1:0] lit_reg, lit_next;
    logic          t1_reg, t1_next;
    logic          t2_reg, t2_next;
    logic          ea_reg, ea_next;
    logic          eot_reg, eot_next;
    logic [15:0]   t1_val_reg, t1_val_next;
    logic [15:0]   t2_val_reg, t2_val_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;

    logic          out_valid_reg, out_valid_next;
    logic [15:0]   out_unit_reg, out_unit_next;
    logic          out_last_reg, out_last_next;
    logic          out_done_reg, out_done_next;

    logic          wr_en;
    logic [15:0]   rd_data;

    // request classification
    logic          is_amp, is_semi, is_ws;
    logic [2:0]    pos;
    logic          pos_ok;
    logic [HESD_NAMES-1:0] mask_base, mask_new;
    logic          dig_dec, dig_hex, dig_ok;
    logic [3:0]    dig_w;
    logic [24:0]   nv;
    logic          num_ok, name_hit, dec_ok, dec_pair;
    logic [15:0]   name_u, dec_u1, dec_u2;
    logic [19:0]   sup_off;
    logic [CW-1:0] cnt_inc;

    logic          pop_last;
    logic [15:0]   pop_unit;

    hesd_ram #(
        .WIDTH (16),
        .DEPTH (LOOKAHEAD)
    ) u_held (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (code_unit),
        .rd_en   (cmd.rd),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    assign is_amp  = (code_unit == CH_AMP);
    assign is_semi = (code_unit == CH_SEMI);
    assign is_ws   = (code_unit >= CH_TAB && code_unit <= CH_CR) ||
                     (code_unit == CH_SPACE) || (code_unit == CH_NBSP);

    assign pos       = cnt_reg[2:0];
    assign pos_ok    = (cnt_reg < CW'(HESD_NAME_MAX));
    assign mask_base = (cnt_reg == '0) ? '1 : mask_reg;
    assign cnt_inc   = cnt_reg + 1'b1;

    always_comb
    begin
        for (int k = 0; k < HESD_NAMES; k++)
        begin
            mask_new[k] = mask_base[k] && pos_ok &&
                          (name_len(4'(k)) > pos) &&
                          (code_unit == {8'h00, name_char(4'(k), pos)});
        end
    end

    always_comb
    begin
        name_hit = 1'b0;
        name_u   = 16'h0000;
        for (int k = HESD_NAMES - 1; k >= 0; k--)
        begin
            if (mask_reg[k] && (CW'(name_len(4'(k))) == cnt_reg))
            begin
                name_hit = 1'b1;
                name_u   = name_unit(4'(k));
            end
        end
    end

    assign dig_dec = (code_unit >= 16'h0030) && (code_unit <= 16'h0039);
    assign dig_hex = hex_reg && (((code_unit >= 16'h0061) && (code_unit <= 16'h0066)) ||
                                 ((code_unit >= 16'h0041) && (code_unit <= 16'h0046)));
    assign dig_ok  = dig_dec || dig_hex;
    assign dig_w   = dig_dec ? code_unit[3:0] : (code_unit[3:0] + 4'd9);
    assign nv      = (hex_reg ? {val_reg, 4'b0000} : (25'(val_reg) * 25'd10)) + 25'(dig_w);

    assign num_ok   = !nfail_reg && (ndig_reg != 4'd0) && (val_reg != '0) &&
                      !((val_reg >= CP_SUR_LO) && (val_reg <= CP_SUR_HI));
    assign dec_ok   = (cnt_reg != '0) && (is_num_reg ? num_ok : name_hit);
    assign dec_pair = is_num_reg && (val_reg >= CP_PLANE1);
    assign sup_off  = 20'(val_reg - CP_PLANE1);
    assign dec_u1   = !is_num_reg ? name_u :
                      dec_pair ? (SUR_LEAD + {6'b0, sup_off[19:10]}) : val_reg[15:0];
    assign dec_u2   = SUR_TRAIL + {6'b0, sup_off[9:0]};

    // next item to leave the queue
    always_comb
    begin
        if (!amp_reg && (lit_reg != '0))
        begin
            pop_last = (lit_reg == CW'(1)) && !t1_reg && !t2_reg && !ea_reg;
        end
        else if (amp_reg)
        begin
            pop_last = (lit_reg == '0) && !t1_reg && !t2_reg && !ea_reg;
        end
        else if (t1_reg)
        begin
            pop_last = !t2_reg && !ea_reg;
        end
        else if (t2_reg)
        begin
            pop_last = !ea_reg;
        end
        else
        begin
            pop_last = 1'b1;
        end
    end

    assign pop_unit = amp_reg ? CH_AMP : t1_reg ? t1_val_reg : t2_reg ? t2_val_reg : CH_AMP;

    always_comb
    begin
        in_ref_next  = in_ref_reg;
        cnt_next     = cnt_reg;
        is_num_next  = is_num_reg;
        hex_next     = hex_reg;
        nfail_next   = nfail_reg;
        ndig_next    = ndig_reg;
        val_next     = val_reg;
        mask_next    = mask_reg;
        amp_next     = amp_reg;
        lit_next     = lit_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        ea_next      = ea_reg;
        eot_next     = eot_reg;
        t1_val_next  = t1_val_reg;
        t2_val_next  = t2_val_reg;
        rd_idx_next  = rd_idx_reg;
        out_unit_next = out_unit_reg;
        out_last_next = out_last_reg;
        out_done_next = out_done_reg;
        out_valid_next = out_valid_reg && out_stall;
        wr_en        = 1'b0;

        if (cmd.take)
        begin
            amp_next    = 1'b0;
            lit_next    = '0;
            t1_next     = 1'b0;
            t2_next     = 1'b0;
            ea_next     = 1'b0;
            eot_next    = end_of_text;
            t1_val_next = code_unit;
            rd_idx_next = '0;

            if (!in_ref_reg)
            begin
                if (is_amp)
                begin
                    in_ref_next = 1'b1;
                    cnt_next    = '0;
                end
                else
                begin
                    t1_next = 1'b1;
                end
            end
            else if (is_semi)
            begin
                in_ref_next = 1'b0;
                cnt_next    = '0;
                if (dec_ok)
                begin
                    t1_next     = 1'b1;
                    t1_val_next = dec_u1;
                    t2_next     = dec_pair;
                    t2_val_next = dec_u2;
                end
                else
                begin
                    amp_next = 1'b1;
                    lit_next = cnt_reg;
                    t1_next  = 1'b1;
                end
            end
            else if (is_amp)
            begin
                amp_next = 1'b1;
                lit_next = cnt_reg;
                cnt_next = '0;
            end
            else if (is_ws)
            begin
                amp_next    = 1'b1;
                lit_next    = cnt_reg;
                t1_next     = 1'b1;
                in_ref_next = 1'b0;
                cnt_next    = '0;
            end
            else
            begin
                wr_en     = 1'b1;
                mask_next = mask_new;
                if (cnt_reg == '0)
                begin
                    is_num_next = (code_unit == CH_HASH);
                    hex_next    = 1'b0;
                    nfail_next  = 1'b0;
                    ndig_next   = 4'd0;
                    val_next    = '0;
                end
                else if (is_num_reg)
                begin
                    if ((cnt_reg == CW'(1)) && (code_unit == CH_LX || code_unit == CH_UX))
                    begin
                        hex_next = 1'b1;
                    end
                    else if (!dig_ok || (ndig_reg == 4'd8) || (nv > 25'(CP_MAX)))
                    begin
                        nfail_next = 1'b1;
                    end
                    else
                    begin
                        val_next  = nv[20:0];
                        ndig_next = ndig_reg + 4'd1;
                    end
                end
                if (cnt_inc == CW'(LOOKAHEAD))
                begin
                    amp_next    = 1'b1;
                    lit_next    = cnt_inc;
                    in_ref_next = 1'b0;
                    cnt_next    = '0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end

            // end of text flushes a pending candidate
            if (end_of_text && in_ref_next)
            begin
                if (in_ref_reg && is_amp)
                begin
                    ea_next = 1'b1;
                end
                else
                begin
                    amp_next = 1'b1;
                    lit_next = cnt_next;
                end
                in_ref_next = 1'b0;
                cnt_next    = '0;
            end
        end
        else if (cmd.push)
        begin
            out_valid_next = 1'b1;
            out_unit_next  = pop_unit;
            out_last_next  = pop_last;
            out_done_next  = pop_last && eot_reg;
            if (amp_reg)
            begin
                amp_next = 1'b0;
            end
            else if (t1_reg)
            begin
                t1_next = 1'b0;
            end
            else if (t2_reg)
            begin
                t2_next = 1'b0;
            end
            else
            begin
                ea_next = 1'b0;
            end
        end
        else if (cmd.push_ram)
        begin
            out_valid_next = 1'b1;
            out_unit_next  = rd_data;
            out_last_next  = pop_last;
            out_done_next  = pop_last && eot_reg;
            lit_next       = lit_reg - 1'b1;
            rd_idx_next    = rd_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ref_reg    <= 1'b0;
            cnt_reg       <= '0;
            amp_reg       <= 1'b0;
            lit_reg       <= '0;
            t1_reg        <= 1'b0;
            t2_reg        <= 1'b0;
            ea_reg        <= 1'b0;
            eot_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_ref_reg    <= in_ref_next;
            cnt_reg       <= cnt_next;
            amp_reg       <= amp_next;
            lit_reg       <= lit_next;
            t1_reg        <= t1_next;
            t2_reg        <= t2_next;
            ea_reg        <= ea_next;
            eot_reg       <= eot_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_num_reg   <= is_num_next;
        hex_reg      <= hex_next;
        nfail_reg    <= nfail_next;
        ndig_reg     <= ndig_next;
        val_reg      <= val_next;
        mask_reg     <= mask_next;
        t1_val_reg   <= t1_val_next;
        t2_val_reg   <= t2_val_next;
        out_unit_reg <= out_unit_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign stat.any      = amp_reg || (lit_reg != '0) || t1_reg || t2_reg || ea_reg;
    assign stat.next_ram = !amp_reg && (lit_reg != '0);
    assign stat.out_free = !out_valid_reg || !out_stall;
    assign stat.pop_last = pop_last;

    assign out_valid   = out_valid_reg;
    assign out_unit    = out_unit_reg;
    assign last_of_run = out_last_reg;
    assign text_done   = out_done_reg;

endmodule

@@ rtl/html_entity_stream_decoder_top.sv @@
// Top level of the HTML character reference stream decoder.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | code_unit[15:0], end_of_text
//  output  | out_valid | out_stall | out_unit[15:0], last_of_run, text_done
//
// A request is accepted in S_IDLE; its results then leave in turn, and each held unit
// replayed from the RAM is first read, then loaded into the result register.
// rst_n clears the control state; the held-unit RAM is not cleared.
// Output stalls hold the result register and pause sequencing; in_stall is high
// from acceptance until the last result of the request is loaded.
`timescale 1ns / 1ps

module html_entity_stream_decoder_top import hesd_pkg::*; #(
    parameter int LOOKAHEAD = HESD_LOOKAHEAD
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_unit,
    output logic        last_of_run,
    output logic        text_done
);

    hesd_cmd_t  cmd;
    hesd_stat_t stat;

    hesd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    hesd_datapath #(
        .LOOKAHEAD (LOOKAHEAD)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_unit    (out_unit),
        .last_of_run (last_of_run),
        .text_done   (text_done)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the HTML character reference stream decoder.
`timescale 1ns / 1ps

module testbench import hesd_pkg::*;;

    localparam logic [15:0] DIG_0  = 16'h0030;
    localparam logic [15:0] DIG_9  = 16'h0039;
    localparam logic [15:0] HEX_LA = 16'h0061;
    localparam logic [15:0] HEX_LF = 16'h0066;
    localparam logic [15:0] HEX_UA = 16'h0041;
    localparam logic [15:0] HEX_UF = 16'h0046;

    class decoded_unit_board;
        typedef struct {
            logic [15:0] unit;
            logic        last;
            logic        done;
        } out_word_t;

        out_word_t   due_q[$];
        logic [15:0] held[HESD_LOOKAHEAD];
        int          held_n;
        bit          open_ref;
        logic [15:0] burst[$];
        string       names[HESD_NAMES];
        logic [15:0] name_codes[HESD_NAMES];
        int          errors;
        int          checked;
        int          decoded;
        int          spilled;

        function new();
            names = '{"nbsp", "amp", "lt", "gt", "quot", "apos", "ensp", "emsp",
                      "thinsp", "middot", "hellip", "ndash", "mdash", "times", "vert"};
            name_codes = '{16'h00A0, 16'h0026, 16'h003C, 16'h003E, 16'h0022,
                           16'h0027, 16'h2002, 16'h2003, 16'h2009, 16'h00B7,
                           16'h2026, 16'h2013, 16'h2014, 16'h00D7, 16'h007C};
            held_n   = 0;
            open_ref = 0;
            errors   = 0;
            checked  = 0;
            decoded  = 0;
            spilled  = 0;
        endfunction

        static function bit is_blank(input logic [15:0] u);
            return (u >= CH_TAB && u <= CH_CR) || u == CH_SPACE || u == CH_NBSP;
        endfunction

        function void add_burst(input logic [15:0] u);
            burst = {burst, u};
        endfunction

        function void spill();
            add_burst(CH_AMP);
            for (int i = 0; i < held_n; i++)
                add_burst(held[i]);
            held_n   = 0;
            open_ref = 0;
            spilled++;
        endfunction

        function bit decode_body();
            bit          hex;
            bit          same;
            int          start;
            int unsigned value;
            int unsigned w;
            int unsigned v;
            logic [15:0] d;
            if (held_n == 0)
                return 0;
            if (held[0] == CH_HASH) begin
                hex   = held_n > 1 && (held[1] == CH_LX || held[1] == CH_UX);
                start = hex ? 2 : 1;
                value = 0;
                if (held_n <= start || held_n - start > 8)
                    return 0;
                for (int i = start; i < held_n; i++) begin
                    d = held[i];
                    if (d >= DIG_0 && d <= DIG_9)
                        w = d - DIG_0;
                    else if (hex && d >= HEX_LA && d <= HEX_LF)
                        w = d - HEX_LA + 10;
                    else if (hex && d >= HEX_UA && d <= HEX_UF)
                        w = d - HEX_UA + 10;
                    else
                        return 0;
                    value = value * (hex ? 16 : 10) + w;
                    if (value > CP_MAX)
                        return 0;
                end
                if (value == 0 || (value >= CP_SUR_LO && value <= CP_SUR_HI))
                    return 0;
                if (value < CP_PLANE1) begin
                    add_burst(value[15:0]);
                end
                else begin
                    v = value - CP_PLANE1;
                    add_burst(SUR_LEAD + 16'(v >> 10));
                    add_burst(SUR_TRAIL + 16'(v & 32'h3FF));
                end
                return 1;
            end
            for (int k = 0; k < HESD_NAMES; k++) begin
                if (names[k].len() != held_n)
                    continue;
                same = 1;
                for (int i = 0; i < held_n; i++)
                    if (held[i] != {8'h00, names[k][i]})
                        same = 0;
                if (same) begin
                    add_burst(name_codes[k]);
                    return 1;
                end
            end
            return 0;
        endfunction

        // accepted request: work out the units it releases
        function void take_code_unit(input logic [15:0] u, input logic eot);
            out_word_t w;
            burst.delete();
            if (!open_ref) begin
                if (u == CH_AMP) begin
                    open_ref = 1;
                    held_n   = 0;
                end
                else begin
                    add_burst(u);
                end
            end
            else if (u == CH_SEMI) begin
                if (decode_body()) begin
                    held_n   = 0;
                    open_ref = 0;
                    decoded++;
                end
                else begin
                    spill();
                    add_burst(u);
                end
            end
            else if (u == CH_AMP) begin
                spill();
                open_ref = 1;
                held_n   = 0;
            end
            else if (is_blank(u)) begin
                spill();
                add_burst(u);
            end
            else begin
                if (held_n < HESD_LOOKAHEAD) begin
                    held[held_n] = u;
                    held_n++;
                end
                if (held_n >= HESD_LOOKAHEAD)
                    spill();
            end
            if (eot) begin
                if (open_ref)
                    spill();
                held_n   = 0;
                open_ref = 0;
            end
            for (int k = 0; k < burst.size(); k++) begin
                w.unit = burst[k];
                w.last = (k == burst.size() - 1);
                w.done = (k == burst.size() - 1) && eot;
                due_q = {due_q, w};
            end
        endfunction

        function void check_out_unit(input logic [15:0] u, input logic l, input logic d);
            out_word_t w;
            checked++;
            if (due_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result out_unit %h last_of_run %b text_done %b",
                         $time, u, l, d);
                return;
            end
            w = due_q.pop_front();
            if (u !== w.unit) begin
                errors++;
                $display("%0t: out_unit expected %h actual %h", $time, w.unit, u);
            end
            if (l !== w.last) begin
                errors++;
                $display("%0t: last_of_run expected %b actual %b", $time, w.last, l);
            end
            if (d !== w.done) begin
                errors++;
                $display("%0t: text_done expected %b actual %b", $time, w.done, d);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [15:0] code_unit   = 16'h0000;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [15:0] out_unit;
    logic        last_of_run;
    logic        text_done;

    decoded_unit_board sb = new();
    logic [15:0]       seq_q[$];
    int                units_sent  = 0;
    int                tx_gap_max  = 0;
    bit                pressure_done = 0;

    html_entity_stream_decoder_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_unit    (out_unit),
        .last_of_run (last_of_run),
        .text_done   (text_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_unit(input logic [15:0] u, input logic eot);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        code_unit   <= u;
        end_of_text <= eot;
        do @(posedge clk); while (in_stall);
        sb.take_code_unit(u, eot);
        units_sent++;
    endtask

    task automatic send_queue(input bit eot);
        for (int i = 0; i < seq_q.size(); i++)
            send_unit(seq_q[i], eot && i == seq_q.size() - 1);
        seq_q.delete();
    endtask

    function automatic void add_seq(input logic [15:0] u);
        seq_q = {seq_q, u};
    endfunction

    task automatic queue_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_seq({8'h00, s[i]});
    endtask

    function automatic logic [15:0] body_unit();
        logic [15:0] u;
        do u = 16'($urandom_range(0, 16'hFFFF));
        while (u == CH_AMP || u == CH_SEMI || decoded_unit_board::is_blank(u));
        return u;
    endfunction

    function automatic logic [15:0] junk_unit();
        string pool;
        pool = "abcxyzXAF#0123456789";
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 16'hFFFF));
        return {8'h00, pool[$urandom_range(0, pool.len() - 1)]};
    endfunction

    function automatic string zero_pad(input string s, input int width);
        while (s.len() < width)
            s = {"0", s};
        return s;
    endfunction

    function automatic int unsigned pick_code_point();
        int unsigned v;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 5))
                    0: v = 1;
                    1: v = CP_SUR_LO - 1;
                    2: v = CP_SUR_HI + 1;
                    3: v = CP_PLANE1 - 1;
                    4: v = CP_PLANE1;
                    default: v = CP_MAX;
                endcase
            end
            1: v = $urandom_range(1, 16'hFFFF);
            2: v = $urandom_range(CP_PLANE1, CP_MAX);
            default: v = $urandom_range(1, 16'h7F);
        endcase
        if (v >= CP_SUR_LO && v <= CP_SUR_HI)
            v = v + 32'h800;
        return v;
    endfunction

    function automatic string numeric_text(input int unsigned v, input bit hex, input int width);
        string s;
        if (hex)
            s = $urandom_range(0, 1) ? $sformatf("%0X", v) : $sformatf("%0x", v);
        else
            s = $sformatf("%0d", v);
        s = zero_pad(s, width);
        if (hex)
            s = {$urandom_range(0, 1) ? "x" : "X", s};
        return {"&#", s, ";"};
    endfunction

    task automatic build_sequence(input int kind);
        string       s;
        int          n;
        int unsigned v;
        bit          hex;
        case (kind)
            0, 1: begin
                n = $urandom_range(1, 6);
                repeat (n) add_seq(16'($urandom_range(0, 16'hFFFF)));
            end
            2, 3: begin
                s = sb.names[$urandom_range(0, HESD_NAMES - 1)];
                if ($urandom_range(0, 4) == 0) begin
                    n = $urandom_range(0, s.len() - 1);
                    s[n] = s[n] ^ 8'h20;
                end
                queue_str({"&", s, ";"});
            end
            4, 5: begin
                v   = pick_code_point();
                hex = (kind == 5);
                queue_str(numeric_text(v, hex, $urandom_range(1, 8)));
            end
            6: begin
                hex = $urandom_range(0, 1);
                case ($urandom_range(0, 5))
                    0: queue_str(numeric_text(0, hex, $urandom_range(1, 8)));
                    1: queue_str(numeric_text($urandom_range(CP_SUR_LO, CP_SUR_HI), hex, 1));
                    2: queue_str(hex ? numeric_text($urandom_range(CP_MAX + 1, 32'hFFFFFFFF), 1, 1)
                                     : numeric_text($urandom_range(CP_MAX + 1, 99999999), 0, 1));
                    3: queue_str(numeric_text(pick_code_point(), hex, 9));
                    4: queue_str(hex ? "&#x;" : "&#;");
                    default: begin
                        s = $sformatf("%0d", pick_code_point());
                        s = $urandom_range(0, 1) ? {s, hex ? "g" : "a"} : {":", s};
                        queue_str({hex ? "&#x" : "&#", s, ";"});
                    end
                endcase
            end
            7: begin
                add_seq(CH_AMP);
                n = $urandom_range(0, 8);
                repeat (n) add_seq(junk_unit());
                add_seq(CH_SEMI);
            end
            8: begin
                add_seq(CH_AMP);
                n = $urandom_range(0, 5);
                repeat (n) add_seq(body_unit());
                queue_str({"&", sb.names[$urandom_range(0, HESD_NAMES - 1)], ";"});
            end
            9: begin
                add_seq(CH_AMP);
                n = $urandom_range(0, 5);
                repeat (n) add_seq(body_unit());
                case ($urandom_range(0, 2))
                    0: add_seq(CH_SPACE);
                    1: add_seq(CH_NBSP);
                    default: add_seq(16'($urandom_range(CH_TAB, CH_CR)));
                endcase
            end
            10: begin
                add_seq(CH_AMP);
                n = $urandom_range(HESD_LOOKAHEAD - 1, HESD_LOOKAHEAD + 2);
                repeat (n) add_seq(body_unit());
                if ($urandom_range(0, 1))
                    add_seq(CH_SEMI);
            end
            default: begin
                queue_str($urandom_range(0, 1) ? "&;" : "&");
            end
        endcase
        n = $urandom_range(0, 2);
        repeat (n) add_seq(16'($urandom_range(0, 16'hFFFF)));
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin
        int gap;
        int rx_gap_max;
        rx_gap_max = 0;
        wait (rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0)
                rx_gap_max = $urandom_range(0, 2) == 0 ? 0 : 18;
            if (sb.checked == 90 && !pressure_done) begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                pressure_done = 1;
            end
            else begin
                gap = $urandom_range(0, rx_gap_max);
                if (gap > 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.check_out_unit(out_unit, last_of_run, text_done);
        end
    end

    initial
    begin
        int cut;
        bit eot;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_unit(16'h0000, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        queue_str("&lt;&;&a&b&q &#0;&#65;");
        send_queue(1'b0);
        queue_str("&x");
        send_queue(1'b1);

        tx_gap_max = 3;
        build_sequence(10);
        send_queue(1'b0);

        while (units_sent < 270) begin
            case ($urandom_range(0, 2))
                0: tx_gap_max = 0;
                1: tx_gap_max = 3;
                default: tx_gap_max = 18;
            endcase
            build_sequence($urandom_range(0, 11));
            eot = ($urandom_range(0, 5) == 0);
            if (eot) begin
                cut = $urandom_range(1, seq_q.size());
                seq_q = seq_q[0:cut - 1];
            end
            send_queue(eot);
        end
        in_valid <= 1'b0;

        while (sb.due_q.size() > 0) @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Sent %0d code units; checked %0d output units.", units_sent, sb.checked);
        $display("References decoded: %0d, emitted literally: %0d, long output hold-off: %0d.",
                 sb.decoded, sb.spilled, pressure_done);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
